@@ design/multi_channel_byte_fifo_defines.svh @@
// Assertion macros for the multi-channel byte FIFO.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MULTI_CHANNEL_BYTE_FIFO_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_FIFO_DEFINES_SVH

// Checked on every rising edge outside reset.
`define MCBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MCBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/mcbf_pkg.sv @@
// Shared constants, codes and beat types of the multi-channel byte FIFO.
// No dependencies.
package mcbf_pkg;

  localparam int NUM_CHANNELS_DEF  = 32;
  localparam int CHANNEL_DEPTH_DEF = 1024;

  localparam int ACT_W    = 3;
  localparam int CH_W     = 5;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 11;
  localparam int COUNT_W  = 8;

  localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_OPEN   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLOSE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EOS       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY_NB  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY_BLK = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NO_READER = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL_NB   = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_FULL_BLK  = 3'd6;
  localparam logic [STATUS_W-1:0] STAT_NO_CHAN   = 3'd7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_CREATE,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_WRITE,
    KIND_READ,
    KIND_RANGE
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] data;
    logic              open_rd;
    logic              open_wr;
    logic              open_nb;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic                moved;
    logic [CH_W-1:0]     channel;
    logic [FILL_W-1:0]   fill;
  } res_t;

endpackage

@@ design/multi_channel_byte_fifo.sv @@
// Top level of the multi-channel byte FIFO: front end, back end, result queue.
// Depends on mcbf_pkg, mcbf_front, mcbf_back and mcbf_out.
//
//   channel   handshake        beat fields
//   input     push / full      action, channel, data_in, open_read/write/nonblock
//   result    empty / pop      status, data_out, bytes_moved, channel_out, fill_level
//
// In the back end a beat passes SM_IDLE, which updates the channel state and
// accesses the byte store, then SM_DONE, which pushes the result with the
// registered store read. Two command and two result slots decouple the sides;
// the back end takes no new beat until the last result has been pushed.
// Reset clears all channel state at once; the byte store is never cleared.
module multi_channel_byte_fifo #(
  parameter int NUM_CHANNELS  = mcbf_pkg::NUM_CHANNELS_DEF,
  parameter int CHANNEL_DEPTH = mcbf_pkg::CHANNEL_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [mcbf_pkg::ACT_W-1:0]    action_i,
  input  logic [mcbf_pkg::CH_W-1:0]     channel_i,
  input  logic [mcbf_pkg::DATA_W-1:0]   data_in_i,
  input  logic                          open_read_i,
  input  logic                          open_write_i,
  input  logic                          open_nonblock_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [mcbf_pkg::STATUS_W-1:0] status_o,
  output logic [mcbf_pkg::DATA_W-1:0]   data_out_o,
  output logic                          bytes_moved_o,
  output logic [mcbf_pkg::CH_W-1:0]     channel_out_o,
  output logic [mcbf_pkg::FILL_W-1:0]   fill_level_o
);
  import mcbf_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  logic res_push, res_full;
  res_t res;

  mcbf_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .action_i        (action_i),
    .channel_i       (channel_i),
    .data_in_i       (data_in_i),
    .open_read_i     (open_read_i),
    .open_write_i    (open_write_i),
    .open_nonblock_i (open_nonblock_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  mcbf_back #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .CHANNEL_DEPTH (CHANNEL_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  mcbf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_push_i    (res_push),
    .res_i         (res),
    .res_full_o    (res_full),
    .empty_o       (empty),
    .pop_i         (pop),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .bytes_moved_o (bytes_moved_o),
    .channel_out_o (channel_out_o),
    .fill_level_o  (fill_level_o)
  );

endmodule

@@ design/mcbf_front.sv @@
// Front end: accepts input beats, classifies them and queues commands.
// Depends on mcbf_pkg.
module mcbf_front #(
  parameter int NUM_CHANNELS = mcbf_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [mcbf_pkg::ACT_W-1:0]  action_i,
  input  logic [mcbf_pkg::CH_W-1:0]   channel_i,
  input  logic [mcbf_pkg::DATA_W-1:0] data_in_i,
  input  logic                        open_read_i,
  input  logic                        open_write_i,
  input  logic                        open_nonblock_i,
  output logic                        cmd_valid_o,
  output mcbf_pkg::cmd_t              cmd_o,
  input  logic                        cmd_pop_i
);
  import mcbf_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  cmd_t       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       push_ok, pop_ok;

  always_comb begin
    cmd_in.channel  = channel_i;
    cmd_in.data     = data_in_i;
    cmd_in.open_rd  = open_read_i;
    cmd_in.open_wr  = open_write_i;
    cmd_in.open_nb  = open_nonblock_i;
    cmd_in.in_range = (32'(channel_i) < NUM_CHANNELS);
    priority if (action_i == ACT_CREATE) begin
      cmd_in.kind = KIND_CREATE;
    end else if (!cmd_in.in_range) begin
      cmd_in.kind = KIND_RANGE;
    end else if (action_i == ACT_OPEN) begin
      cmd_in.kind = KIND_OPEN;
    end else if (action_i == ACT_CLOSE) begin
      cmd_in.kind = KIND_CLOSE;
    end else if (action_i == ACT_WRITE) begin
      cmd_in.kind = KIND_WRITE;
    end else if (action_i == ACT_READ) begin
      cmd_in.kind = KIND_READ;
    end else begin
      cmd_in.kind = KIND_NOP;
    end
  end

  assign full_o      = (cnt_q == QDEPTH);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = push_ok ? ~wr_q : wr_q;
    rd_d  = pop_ok ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      ent_q[wr_q] <= cmd_in;
    end
  end

endmodule

@@ design/mcbf_back.sv @@
// Back end: per-channel state, byte store and command execution.
// Depends on mcbf_pkg and multi_channel_byte_fifo_defines.svh.
`include "multi_channel_byte_fifo_defines.svh"

module mcbf_back #(
  parameter int NUM_CHANNELS  = mcbf_pkg::NUM_CHANNELS_DEF,
  parameter int CHANNEL_DEPTH = mcbf_pkg::CHANNEL_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  mcbf_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_push_o,
  output mcbf_pkg::res_t res_o,
  input  logic           res_full_i
);
  import mcbf_pkg::*;

  localparam int ADDR_CH   = (NUM_CHANNELS < 32) ? NUM_CHANNELS : 32;
  localparam int IDX_W     = (ADDR_CH > 1) ? $clog2(ADDR_CH) : 1;
  localparam int PTR_W     = $clog2(CHANNEL_DEPTH);
  localparam int CNT_W     = $clog2(CHANNEL_DEPTH + 1);
  localparam int MEM_DEPTH = ADDR_CH * CHANNEL_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(CHANNEL_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(CHANNEL_DEPTH);
  localparam logic [ADDR_W-1:0] CH_SPAN  = ADDR_W'(CHANNEL_DEPTH);

  localparam logic SM_IDLE = 1'b0;
  localparam logic SM_DONE = 1'b1;

  logic [PTR_W-1:0]   rp_q  [ADDR_CH];
  logic [PTR_W-1:0]   wp_q  [ADDR_CH];
  logic [CNT_W-1:0]   cnt_q [ADDR_CH];
  logic [COUNT_W-1:0] rdr_q [ADDR_CH];
  logic [COUNT_W-1:0] wtr_q [ADDR_CH];
  logic               nb_q  [ADDR_CH];

  logic [DATA_W-1:0]  mem_q [MEM_DEPTH];
  logic [DATA_W-1:0]  mem_rdata_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [PTR_W-1:0]   mem_ptr;

  logic               state_q, state_d;
  res_t               res_q, res_d;
  logic               rd_hit_q, rd_hit_d;
  logic               fire;

  logic [ADDR_CH-1:0] free;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   idx, upd_idx;
  logic               upd;

  logic [PTR_W-1:0]   cur_rp, cur_wp, rp_d, wp_d;
  logic [CNT_W-1:0]   cur_cnt, cnt_d;
  logic [COUNT_W-1:0] cur_rdr, cur_wtr, rdr_d, wtr_d;
  logic               cur_nb, nb_d;

  assign fire       = (state_q == SM_IDLE) && cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = (state_q == SM_DONE);
  assign idx        = cmd_i.channel[IDX_W-1:0];

  always_comb begin
    res_o = res_q;
    if (rd_hit_q) begin
      res_o.data = mem_rdata_q;
    end
  end

  always_comb begin
    for (int i = 0; i < ADDR_CH; i++) begin
      free[i] = (rdr_q[i] == '0) && (wtr_q[i] == '0);
    end
    free_any = |free;
    free_idx = '0;
    for (int i = ADDR_CH - 1; i >= 0; i--) begin
      if (free[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cur_rp  = rp_q[idx];
    cur_wp  = wp_q[idx];
    cur_cnt = cnt_q[idx];
    cur_rdr = rdr_q[idx];
    cur_wtr = wtr_q[idx];
    cur_nb  = nb_q[idx];
  end

  always_comb begin
    upd      = 1'b0;
    upd_idx  = idx;
    rp_d     = cur_rp;
    wp_d     = cur_wp;
    cnt_d    = cur_cnt;
    rdr_d    = cur_rdr;
    wtr_d    = cur_wtr;
    nb_d     = cur_nb;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    rd_hit_d = 1'b0;
    res_d.status  = STAT_OK;
    res_d.data    = '0;
    res_d.moved   = 1'b0;
    res_d.channel = cmd_i.channel;
    res_d.fill    = FILL_W'(cur_cnt);
    unique case (cmd_i.kind)
      KIND_CREATE: begin
        if (free_any) begin
          upd           = 1'b1;
          upd_idx       = free_idx;
          rp_d          = '0;
          wp_d          = '0;
          cnt_d         = '0;
          nb_d          = 1'b0;
          rdr_d         = COUNT_W'(1);
          wtr_d         = COUNT_W'(1);
          res_d.channel = CH_W'(free_idx);
          res_d.fill    = '0;
        end else begin
          res_d.status = STAT_NO_CHAN;
          res_d.fill   = cmd_i.in_range ? FILL_W'(cur_cnt) : '0;
        end
      end
      KIND_OPEN: begin
        upd = 1'b1;
        if (cmd_i.open_rd && (cur_rdr != COUNT_MAX)) begin
          rdr_d = cur_rdr + 1'b1;
        end
        if (cmd_i.open_wr && (cur_wtr != COUNT_MAX)) begin
          wtr_d = cur_wtr + 1'b1;
        end
        nb_d = cur_nb | cmd_i.open_nb;
      end
      KIND_CLOSE: begin
        upd   = 1'b1;
        rdr_d = (cur_rdr != '0) ? cur_rdr - 1'b1 : '0;
        wtr_d = (cur_wtr != '0) ? cur_wtr - 1'b1 : '0;
        if ((rdr_d == '0) && (wtr_d == '0)) begin
          rp_d  = '0;
          wp_d  = '0;
          cnt_d = '0;
        end
        res_d.fill = FILL_W'(cnt_d);
      end
      KIND_WRITE: begin
        if (cur_rdr == '0) begin
          res_d.status = STAT_NO_READER;
        end else if (cur_cnt == CNT_FULL) begin
          res_d.status = cur_nb ? STAT_FULL_NB : STAT_FULL_BLK;
        end else begin
          upd         = 1'b1;
          mem_we      = 1'b1;
          wp_d        = (cur_wp == PTR_LAST) ? '0 : cur_wp + 1'b1;
          cnt_d       = cur_cnt + 1'b1;
          res_d.moved = 1'b1;
          res_d.fill  = FILL_W'(cnt_d);
        end
      end
      KIND_READ: begin
        if (cur_cnt == '0) begin
          priority if (cur_wtr == '0) begin
            res_d.status = STAT_EOS;
          end else if (cur_nb) begin
            res_d.status = STAT_EMPTY_NB;
          end else begin
            res_d.status = STAT_EMPTY_BLK;
          end
          res_d.fill = '0;
        end else begin
          upd         = 1'b1;
          mem_re      = 1'b1;
          rd_hit_d    = 1'b1;
          rp_d        = (cur_rp == PTR_LAST) ? '0 : cur_rp + 1'b1;
          cnt_d       = cur_cnt - 1'b1;
          res_d.moved = 1'b1;
          res_d.fill  = FILL_W'(cnt_d);
        end
      end
      KIND_RANGE: begin
        res_d.status = STAT_NO_CHAN;
        res_d.fill   = '0;
      end
      KIND_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_ptr  = (cmd_i.kind == KIND_WRITE) ? cur_wp : cur_rp;
    mem_addr = ADDR_W'(idx) * CH_SPAN + ADDR_W'(mem_ptr);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SM_IDLE: begin
        if (fire) begin
          state_d = SM_DONE;
        end
      end
      SM_DONE: begin
        state_d = SM_IDLE;
      end
      default: begin
        state_d = SM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SM_IDLE;
      for (int i = 0; i < ADDR_CH; i++) begin
        rp_q[i]  <= '0;
        wp_q[i]  <= '0;
        cnt_q[i] <= '0;
        rdr_q[i] <= '0;
        wtr_q[i] <= '0;
        nb_q[i]  <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (fire && upd) begin
        rp_q[upd_idx]  <= rp_d;
        wp_q[upd_idx]  <= wp_d;
        cnt_q[upd_idx] <= cnt_d;
        rdr_q[upd_idx] <= rdr_d;
        wtr_q[upd_idx] <= wtr_d;
        nb_q[upd_idx]  <= nb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q    <= res_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && mem_we) begin
      mem_q[mem_addr] <= cmd_i.data;
    end
    if (fire && mem_re) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  `MCBF_ASSERT(a_pop_then_push, cmd_pop_o |=> res_push_o, "command taken without result")
  `MCBF_ASSERT(a_push_has_room, res_push_o |-> !res_full_i, "result pushed into full queue")
  `MCBF_ASSERT(a_read_hit_ok, (res_push_o && rd_hit_q) |-> res_q.moved, "read without data")
  `MCBF_ASSERT_ALWAYS(a_no_pop_in_done, (state_q == SM_DONE) |-> !cmd_pop_o, "taken while busy")

endmodule

@@ design/mcbf_out.sv @@
// Result queue: holds finished result beats until popped.
// Depends on mcbf_pkg.
module mcbf_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_push_i,
  input  mcbf_pkg::res_t                res_i,
  output logic                          res_full_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [mcbf_pkg::STATUS_W-1:0] status_o,
  output logic [mcbf_pkg::DATA_W-1:0]   data_out_o,
  output logic                          bytes_moved_o,
  output logic [mcbf_pkg::CH_W-1:0]     channel_out_o,
  output logic [mcbf_pkg::FILL_W-1:0]   fill_level_o
);
  import mcbf_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  res_t       ent_q [2];
  res_t       head;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok, pop_ok;

  assign res_full_o = (cnt_q == QDEPTH);
  assign empty_o    = (cnt_q == 2'd0);
  assign push_ok    = res_push_i && !res_full_o;
  assign pop_ok     = pop_i && !empty_o;
  assign head       = ent_q[rd_q];

  assign status_o      = head.status;
  assign data_out_o    = head.data;
  assign bytes_moved_o = head.moved;
  assign channel_out_o = head.channel;
  assign fill_level_o  = head.fill;

  always_comb begin
    wr_d  = push_ok ? ~wr_q : wr_q;
    rd_d  = pop_ok ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      ent_q[wr_q] <= res_i;
    end
  end

endmodule

@@ sim/multi_channel_byte_fifo_test.sv @@
// Self-checking bench for multi_channel_byte_fifo: drives command beats, predicts each
// result from a channel-bank model and checks every result beat in order.
// Depends on mcbf_pkg and the multi_channel_byte_fifo RTL.
module multi_channel_byte_fifo_test;
  import mcbf_pkg::*;

  localparam int NCH       = NUM_CHANNELS_DEF;
  localparam int DEPTH     = CHANNEL_DEPTH_DEF;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int LOOKAHEAD = 0;
  localparam int CHECKER   = 1;
  localparam int HOLD_LEN  = 400;
  localparam int TAIL_LEN  = 20;
  localparam int STALL_MAX = 5000;

  localparam logic [ACT_W-1:0]  ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0]  ACT_SPARE_HI = 3'd7;
  localparam logic [FILL_W-1:0] FULL_LEVEL   = FILL_W'(DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST     = PTR_W'(DEPTH - 1);

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] data;
    logic              rd;
    logic              wr;
    logic              nb;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [ACT_W-1:0] action_i = '0;
  logic [CH_W-1:0] channel_i = '0;
  logic [DATA_W-1:0] data_in_i = '0;
  logic open_read_i = 1'b0;
  logic open_write_i = 1'b0;
  logic open_nonblock_i = 1'b0;
  logic full;
  logic empty;
  logic [STATUS_W-1:0] status_o;
  logic [DATA_W-1:0] data_out_o;
  logic bytes_moved_o;
  logic [CH_W-1:0] channel_out_o;
  logic [FILL_W-1:0] fill_level_o;

  logic [PTR_W-1:0]   rd_ptr   [2][NCH];
  logic [PTR_W-1:0]   wr_ptr   [2][NCH];
  logic [FILL_W-1:0]  fill_cnt [2][NCH];
  logic [COUNT_W-1:0] readers  [2][NCH];
  logic [COUNT_W-1:0] writers  [2][NCH];
  logic               nb_flag  [2][NCH];
  logic [DATA_W-1:0]  byte_mem [2][NCH][DEPTH];

  beat_t pending[$];
  res_t  expected[$];
  beat_t cur_beat;
  res_t  ahead;
  res_t  got;
  res_t  want;
  bit    beat_taken = 1'b0;
  bit    hold_req = 1'b0;
  bit    progress;
  int    hold_left = 0;
  int    tx_idle = 0;
  int    rx_idle = 0;
  int    beats_queued = 0;
  int    beats_taken = 0;
  int    idle_cycles = 0;
  int    mismatches = 0;

  multi_channel_byte_fifo DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .channel_i      (channel_i),
    .data_in_i      (data_in_i),
    .open_read_i    (open_read_i),
    .open_write_i   (open_write_i),
    .open_nonblock_i(open_nonblock_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .bytes_moved_o  (bytes_moved_o),
    .channel_out_o  (channel_out_o),
    .fill_level_o   (fill_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_t fifo_apply(input int v, input beat_t b);
    res_t r;
    int   c;
    int   i;
    bit   found;
    r = '0;
    r.channel = b.channel;
    c = int'(b.channel);
    found = 1'b0;
    case (b.action)
      ACT_CREATE: begin
        r.status = STAT_NO_CHAN;
        for (i = 0; i < NCH && !found; i++) begin
          if (readers[v][i] == '0 && writers[v][i] == '0) begin
            rd_ptr[v][i] = '0;
            wr_ptr[v][i] = '0;
            fill_cnt[v][i] = '0;
            nb_flag[v][i] = 1'b0;
            readers[v][i] = COUNT_W'(1);
            writers[v][i] = COUNT_W'(1);
            r.status = STAT_OK;
            r.channel = CH_W'(i);
            found = 1'b1;
          end
        end
      end
      ACT_OPEN: begin
        r.status = STAT_OK;
        if (b.rd && readers[v][c] < COUNT_MAX) readers[v][c] = readers[v][c] + 1'b1;
        if (b.wr && writers[v][c] < COUNT_MAX) writers[v][c] = writers[v][c] + 1'b1;
        if (b.nb) nb_flag[v][c] = 1'b1;
      end
      ACT_CLOSE: begin
        r.status = STAT_OK;
        if (readers[v][c] != '0) readers[v][c] = readers[v][c] - 1'b1;
        if (writers[v][c] != '0) writers[v][c] = writers[v][c] - 1'b1;
        if (readers[v][c] == '0 && writers[v][c] == '0) begin
          rd_ptr[v][c] = '0;
          wr_ptr[v][c] = '0;
          fill_cnt[v][c] = '0;
        end
      end
      ACT_WRITE: begin
        if (readers[v][c] == '0) begin
          r.status = STAT_NO_READER;
        end else if (fill_cnt[v][c] >= FULL_LEVEL) begin
          r.status = nb_flag[v][c] ? STAT_FULL_NB : STAT_FULL_BLK;
        end else begin
          r.status = STAT_OK;
          byte_mem[v][c][wr_ptr[v][c]] = b.data;
          wr_ptr[v][c] = (wr_ptr[v][c] == PTR_LAST) ? '0 : wr_ptr[v][c] + 1'b1;
          fill_cnt[v][c] = fill_cnt[v][c] + 1'b1;
          r.moved = 1'b1;
        end
      end
      ACT_READ: begin
        if (fill_cnt[v][c] == '0) begin
          r.status = (writers[v][c] == '0) ? STAT_EOS :
                     (nb_flag[v][c] ? STAT_EMPTY_NB : STAT_EMPTY_BLK);
        end else begin
          r.status = STAT_OK;
          r.data = byte_mem[v][c][rd_ptr[v][c]];
          rd_ptr[v][c] = (rd_ptr[v][c] == PTR_LAST) ? '0 : rd_ptr[v][c] + 1'b1;
          fill_cnt[v][c] = fill_cnt[v][c] - 1'b1;
          r.moved = 1'b1;
        end
      end
      default: r.status = STAT_OK;
    endcase
    r.fill = fill_cnt[v][int'(r.channel)];
    return r;
  endfunction

  task automatic add_beat(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch,
                          input logic [DATA_W-1:0] d, input logic rd, input logic wr,
                          input logic nb);
    beat_t b;
    b = '{action: act, channel: ch, data: d, rd: rd, wr: wr, nb: nb};
    ahead = fifo_apply(LOOKAHEAD, b);
    pending.push_back(b);
    beats_queued++;
  endtask

  task automatic wait_drained();
    while (beats_taken != beats_queued || expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input res_t exp_r, input res_t act_r);
    string exp_s;
    string act_s;
    mismatches++;
    if (mismatches <= 10) begin
      exp_s = $sformatf("st %0d data %h mv %0d ch %0d fill %0d", exp_r.status, exp_r.data,
                        exp_r.moved, exp_r.channel, exp_r.fill);
      act_s = $sformatf("st %0d data %h mv %0d ch %0d fill %0d", act_r.status, act_r.data,
                        act_r.moved, act_r.channel, act_r.fill);
      $display("%0t %s: expected %s, got %s", $realtime, what, exp_s, act_s);
    end
  endtask

  task automatic run_random(input int n);
    int made;
    int live[$];
    int c;
    int k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 25) begin
        add_beat(($urandom_range(0, 19) == 0) ? ACT_W'($urandom_range(5, 7))
                                              : ACT_W'($urandom_range(0, 4)),
                 CH_W'($urandom), DATA_W'($urandom), 1'($urandom), 1'($urandom),
                 1'($urandom));
        made++;
      end else begin
        live.delete();
        for (k = 0; k < NCH; k++)
          if (readers[LOOKAHEAD][k] != '0 || writers[LOOKAHEAD][k] != '0) live.push_back(k);
        if (live.size() == 0 || (live.size() < 6 && $urandom_range(0, 3) == 0)) begin
          add_beat(ACT_CREATE, CH_W'($urandom), DATA_W'($urandom), 1'b0, 1'b0, 1'b0);
          made++;
          c = int'(ahead.channel);
        end else begin
          c = live[$urandom_range(0, live.size() - 1)];
        end
        if ($urandom_range(0, 4) == 0) begin
          add_beat(ACT_OPEN, CH_W'(c), DATA_W'($urandom), 1'($urandom), 1'($urandom),
                   ($urandom_range(0, 2) == 0));
          made++;
        end
        repeat ($urandom_range(0, 16)) begin
          add_beat(ACT_WRITE, CH_W'(c), DATA_W'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom));
          made++;
        end
        repeat ($urandom_range(0, 18)) begin
          add_beat(ACT_READ, CH_W'(c), DATA_W'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom));
          made++;
        end
        if ($urandom_range(0, 5) == 0) begin
          add_beat(ACT_CLOSE, CH_W'(c), DATA_W'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom));
          made++;
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!push || beat_taken)) begin
      beat_taken = 1'b0;
      if (pending.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
        cur_beat = pending.pop_front();
        push <= 1'b1;
        action_i <= cur_beat.action;
        channel_i <= cur_beat.channel;
        data_in_i <= cur_beat.data;
        open_read_i <= cur_beat.rd;
        open_write_i <= cur_beat.wr;
        open_nonblock_i <= cur_beat.nb;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (push && !full) begin
        expected.push_back(fifo_apply(CHECKER, cur_beat));
        beat_taken = 1'b1;
        beats_taken++;
        progress = 1'b1;
      end
      if (pop && !empty) begin
        progress = 1'b1;
        got = '{status: status_o, data: data_out_o, moved: bytes_moved_o,
                channel: channel_out_o, fill: fill_level_o};
        if (expected.size() == 0) begin
          note_mismatch("result beat with nothing expected", '0, got);
        end else begin
          want = expected.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.moved !== want.moved || got.channel !== want.channel ||
              got.fill !== want.fill)
            note_mismatch("result beat mismatch", want, got);
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_MAX) @(negedge clk_i);
    $display("timeout: no beat moved for %0d cycles", STALL_MAX);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int v = 0; v < 2; v++) begin
      for (int c = 0; c < NCH; c++) begin
        rd_ptr[v][c] = '0;
        wr_ptr[v][c] = '0;
        fill_cnt[v][c] = '0;
        readers[v][c] = '0;
        writers[v][c] = '0;
        nb_flag[v][c] = 1'b0;
      end
    end
    tx_idle = 32;
    rx_idle = 51;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_beat(ACT_READ, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_WRITE, 5'd31, 8'hFF, 1'b1, 1'b1, 1'b1);
    add_beat(ACT_CLOSE, 5'd5, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_CREATE, 5'd17, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_READ, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_WRITE, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_WRITE, 5'd0, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_WRITE, 5'd0, 8'hA5, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_READ, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_OPEN, 5'd0, 8'h00, 1'b1, 1'b0, 1'b0);
    add_beat(ACT_OPEN, 5'd0, 8'h00, 1'b0, 1'b1, 1'b1);
    add_beat(ACT_OPEN, 5'd31, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_READ, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_READ, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_READ, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_CLOSE, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_CLOSE, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_CLOSE, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_READ, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_WRITE, 5'd0, 8'h5A, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_CREATE, 5'd31, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_CREATE, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_SPARE_LO, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_beat(ACT_SPARE_HI, 5'd31, 8'hFF, 1'b1, 1'b1, 1'b1);
    wait_drained();

    // exhaust the channel bank, then release every channel
    do begin
      add_beat(ACT_CREATE, CH_W'($urandom), DATA_W'($urandom), 1'b0, 1'b0, 1'b0);
    end while (ahead.status != STAT_NO_CHAN);
    for (int c = 0; c < NCH; c++)
      while (readers[LOOKAHEAD][c] != '0 || writers[LOOKAHEAD][c] != '0)
        add_beat(ACT_CLOSE, CH_W'(c), 8'h00, 1'b0, 1'b0, 1'b0);
    wait_drained();

    // fill one channel past full while the result side holds off
    hold_req = 1'b1;
    add_beat(ACT_CREATE, 5'd9, 8'h00, 1'b0, 1'b0, 1'b0);
    begin
      logic [CH_W-1:0] fc;
      fc = ahead.channel;
      repeat (DEPTH + 1) add_beat(ACT_WRITE, fc, DATA_W'($urandom), 1'b0, 1'b0, 1'b0);
      add_beat(ACT_OPEN, fc, 8'h00, 1'b0, 1'b0, 1'b1);
      add_beat(ACT_WRITE, fc, DATA_W'($urandom), 1'b0, 1'b0, 1'b0);
      repeat (8) add_beat(ACT_READ, fc, 8'h00, 1'b0, 1'b0, 1'b0);
      add_beat(ACT_CLOSE, fc, 8'h00, 1'b0, 1'b0, 1'b0);
    end
    wait_drained();

    run_random(20);
    wait_drained();
    tx_idle = 51;
    rx_idle = 32;
    run_random(20);
    wait_drained();
    tx_idle = 0;
    rx_idle = 0;
    run_random(20);
    wait_drained();
    repeat (TAIL_LEN) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
